@@ hdl/teadec_pkg.sv @@
// Shared types, constants and the round mixing function for the TEA block decryptor.
`default_nettype none

package teadec_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CFG_IDX_W = 8;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Key schedule constant
  localparam word_t TEA_DELTA = 32'h9E37_79B9;

  // Configuration register indexes
  localparam cfg_idx_t KEY_WORD0_IDX = 8'd0;
  localparam cfg_idx_t KEY_WORD1_IDX = 8'd1;
  localparam cfg_idx_t KEY_WORD2_IDX = 8'd2;
  localparam cfg_idx_t KEY_WORD3_IDX = 8'd3;

  // Feistel mixing term: ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb), all mod 2^32
  function automatic word_t mix_word(word_t x, word_t sum, word_t ka, word_t kb);
    word_t a;
    word_t b;
    word_t c;
    a = (x << 4) + ka;
    b = x + sum;
    c = (x >> 5) + kb;
    return a ^ b ^ c;
  endfunction

endpackage

`default_nettype wire

@@ hdl/teadec_half_round.sv @@
// One registered TEA half round: subtract the mix of one word from the other.
`default_nettype none

module teadec_half_round (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  valid_i,
  input  teadec_pkg::word_t    src_i,
  input  teadec_pkg::word_t    dst_i,
  input  teadec_pkg::word_t    sum_i,
  input  teadec_pkg::word_t    key_a_i,
  input  teadec_pkg::word_t    key_b_i,
  output logic                 valid_o,
  output teadec_pkg::word_t    src_o,
  output teadec_pkg::word_t    dst_o
);
  import teadec_pkg::*;

  logic  valid_q;
  word_t src_q;
  word_t dst_q;
  word_t dst_d;

  // Update the destination word from the source word
  assign dst_d = dst_i - mix_word(src_i, sum_i, key_a_i, key_b_i);

  // Advance the valid bit every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Capture payload; no reset needed
  always_ff @(posedge clk_i) begin
    src_q <= src_i;
    dst_q <= dst_d;
  end

  assign valid_o = valid_q;
  assign src_o   = src_q;
  assign dst_o   = dst_q;

endmodule

`default_nettype wire

@@ hdl/tea_block_decrypt.sv @@
// Top level of the pipelined TEA block decryptor.
//
// Decrypts one 64-bit block per clock with the Tiny Encryption Algorithm. A block is taken
// at every rising edge where start_i is high; busy_o stays low, so a new block may follow
// in every cycle. Each round is split into two half-round register stages, so a block
// leaves the pipeline through the last of its half-round stages with done_o high for
// exactly one cycle alongside plain_left_o and plain_right_o. Results come out in the order
// blocks went in, and the receiver must take each one in the cycle it is shown. The four
// key words are written through the cfg_* port (indexes 0 to 3; other indexes are dropped)
// and should only change while no block is in flight.
`default_nettype none

module tea_block_decrypt #(
  parameter int unsigned ROUND_COUNT = 32
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  // Block input
  input  wire                      start_i,
  output logic                     busy_o,
  input  teadec_pkg::word_t        cipher_left_i,
  input  teadec_pkg::word_t        cipher_right_i,
  // Block output
  output logic                     done_o,
  output teadec_pkg::word_t        plain_left_o,
  output teadec_pkg::word_t        plain_right_o,
  // Key configuration
  input  wire                      cfg_valid_i,
  output logic                     cfg_ready_o,
  input  teadec_pkg::cfg_idx_t     cfg_index_i,
  input  teadec_pkg::word_t        cfg_data_i
);
  import teadec_pkg::*;

  localparam int unsigned STAGES = 2 * ROUND_COUNT;

  word_t key0_q;
  word_t key1_q;
  word_t key2_q;
  word_t key3_q;

  logic  vld   [0:STAGES];
  word_t left  [0:STAGES];
  word_t right [0:STAGES];

  // Accept every transfer; the pipeline never stalls
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Hold key words; drop writes to unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q <= '0;
      key1_q <= '0;
      key2_q <= '0;
      key3_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        KEY_WORD0_IDX: key0_q <= cfg_data_i;
        KEY_WORD1_IDX: key1_q <= cfg_data_i;
        KEY_WORD2_IDX: key2_q <= cfg_data_i;
        KEY_WORD3_IDX: key3_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline entry
  assign vld[0]   = start_i && !busy_o;
  assign left[0]  = cipher_left_i;
  assign right[0] = cipher_right_i;

  // Two half-round stages per round; even stages update the right word
  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam int unsigned     RND     = s / 2;
    localparam logic [63:0]     SUM_W64 = 64'(TEA_DELTA) * 64'(ROUND_COUNT - RND);
    localparam word_t           SUM     = SUM_W64[WORD_W-1:0];

    if ((s % 2) == 0) begin : g_right
      teadec_half_round u_half (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .valid_i (vld[s]),
        .src_i   (left[s]),
        .dst_i   (right[s]),
        .sum_i   (SUM),
        .key_a_i (key2_q),
        .key_b_i (key3_q),
        .valid_o (vld[s+1]),
        .src_o   (left[s+1]),
        .dst_o   (right[s+1])
      );
    end else begin : g_left
      teadec_half_round u_half (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .valid_i (vld[s]),
        .src_i   (right[s]),
        .dst_i   (left[s]),
        .sum_i   (SUM),
        .key_a_i (key0_q),
        .key_b_i (key1_q),
        .valid_o (vld[s+1]),
        .src_o   (right[s+1]),
        .dst_o   (left[s+1])
      );
    end
  end

  // Present the last stage
  assign done_o        = vld[STAGES];
  assign plain_left_o  = left[STAGES];
  assign plain_right_o = right[STAGES];

endmodule

`default_nettype wire

@@ hdl/teadec_check.sv @@
// Port-level checks for the TEA block decryptor, bound to the top level.
`default_nettype none

module teadec_check #(
  parameter int unsigned LAT = 64
) (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  start_i,
  input wire                  busy_o,
  input wire                  done_o,
  input wire                  cfg_valid_i,
  input wire                  cfg_ready_o
);

  // Every result traces back to a block taken a fixed latency earlier
  a_done_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("done_o without a block taken LAT cycles before");

  // No result right after reset release
  a_quiet_after_reset: assert property (@(posedge clk_i)
    rst_ni && $past(!rst_ni) |-> !done_o)
    else $error("done_o high right after reset");

  // Blocks are never refused
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_o)
    else $error("start refused while busy");

  // Key writes are never refused
  a_cfg_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind tea_block_decrypt teadec_check #(.LAT(2 * ROUND_COUNT)) u_teadec_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);

`default_nettype wire

@@ dv/tea_block_decrypt_test.sv @@
// Self-checking testbench for the pipelined TEA block decryptor, with its own deciphering model.
module tea_block_decrypt_test;
  timeunit 1ns;
  timeprecision 1ps;

  import teadec_pkg::*;

  localparam int unsigned ROUNDS      = 32;
  localparam int unsigned PIPE_DEPTH  = 2 * ROUNDS;
  localparam int unsigned MAX_GAP     = 14;
  localparam int unsigned PHASE_COUNT = 9;
  localparam int unsigned PHASE_ITEMS = 100;

  typedef struct packed {
    word_t left;
    word_t right;
  } plain_pair_t;

  logic     clk_i          = 1'b0;
  logic     rst_ni         = 1'b0;
  logic     start_i        = 1'b0;
  word_t    cipher_left_i  = '0;
  word_t    cipher_right_i = '0;
  logic     cfg_valid_i    = 1'b0;
  cfg_idx_t cfg_index_i    = '0;
  word_t    cfg_data_i     = '0;
  logic     busy_o;
  logic     done_o;
  word_t    plain_left_o;
  word_t    plain_right_o;
  logic     cfg_ready_o;

  // Shadow copy of the key and the plaintext blocks still in flight
  word_t       key_shadow [4];
  plain_pair_t pending_plain [$];
  int          error_count  = 0;
  bit          steady_flow  = 1'b0;

  tea_block_decrypt #(
    .ROUND_COUNT(ROUNDS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .cipher_left_i (cipher_left_i),
    .cipher_right_i(cipher_right_i),
    .done_o        (done_o),
    .plain_left_o  (plain_left_o),
    .plain_right_o (plain_right_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Run all rounds backward with the shadow key, sum counting down from delta * rounds
  function automatic plain_pair_t decipher_block(word_t cl, word_t cr);
    word_t l;
    word_t r;
    word_t sum;
    word_t t;
    plain_pair_t res;
    l   = cl;
    r   = cr;
    sum = word_t'(TEA_DELTA * ROUNDS);
    for (int i = 0; i < ROUNDS; i++) begin
      t   = ((l << 4) + key_shadow[2]) ^ (l + sum) ^ ((l >> 5) + key_shadow[3]);
      r   = r - t;
      t   = ((r << 4) + key_shadow[0]) ^ (r + sum) ^ ((r >> 5) + key_shadow[1]);
      l   = l - t;
      sum = sum - TEA_DELTA;
    end
    res.left  = l;
    res.right = r;
    return res;
  endfunction

  // Mostly random words, with the all-zero and all-one corners mixed in
  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned draw_gap();
    return steady_flow ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Write one key register; indexes past the key words must leave the key alone
  task automatic write_key(cfg_idx_t idx, word_t data);
    int unsigned gap;
    gap = draw_gap();
    @(posedge clk_i);
    repeat (gap) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      KEY_WORD0_IDX: key_shadow[0] = data;
      KEY_WORD1_IDX: key_shadow[1] = data;
      KEY_WORD2_IDX: key_shadow[2] = data;
      KEY_WORD3_IDX: key_shadow[3] = data;
      default: ;
    endcase
  endtask

  task automatic write_all_keys(word_t k0, word_t k1, word_t k2, word_t k3);
    write_key(KEY_WORD0_IDX, k0);
    write_key(KEY_WORD1_IDX, k1);
    write_key(KEY_WORD2_IDX, k2);
    write_key(KEY_WORD3_IDX, k3);
  endtask

  // Offer one block; start stays high after the transfer so a zero gap keeps the flow going
  task automatic send_block(word_t cl, word_t cr);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    cipher_left_i  <= cl;
    cipher_right_i <= cr;
    do @(posedge clk_i); while (busy_o);
    pending_plain.push_back(decipher_block(cl, cr));
  endtask

  // Drop start and wait until every block in flight has come out
  task automatic drain_blocks();
    start_i <= 1'b0;
    while (pending_plain.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Compare each result against the oldest expected plaintext
  always @(posedge clk_i) begin : check_results
    plain_pair_t want;
    if (rst_ni && done_o) begin
      if (pending_plain.size() == 0) begin
        $error("unexpected result: plain_left %h plain_right %h", plain_left_o, plain_right_o);
        error_count++;
      end else begin
        want = pending_plain.pop_front();
        if (plain_left_o !== want.left) begin
          $error("plain_left: expected %h, got %h", want.left, plain_left_o);
          error_count++;
        end
        if (plain_right_o !== want.right) begin
          $error("plain_right: expected %h, got %h", want.right, plain_right_o);
          error_count++;
        end
      end
    end
  end

  // Reset key of all zeros against the corner blocks
  task automatic test_reset_key();
    send_block('0, '0);
    send_block('1, '1);
    send_block('0, '1);
    send_block('1, '0);
    send_block(32'hAAAA_AAAA, 32'h5555_5555);
    send_block(32'h8000_0000, 32'h0000_0001);
    drain_blocks();
  endtask

  // All-ones keys, then alternating and single-bit key words
  task automatic test_key_extremes();
    write_all_keys('1, '1, '1, '1);
    send_block('0, '0);
    send_block('1, '1);
    send_block(32'h0123_4567, 32'h89AB_CDEF);
    drain_blocks();
    write_all_keys(32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000, 32'h0000_0001);
    send_block('0, '0);
    send_block('1, '1);
    send_block(32'hFEDC_BA98, 32'h7654_3210);
    drain_blocks();
  endtask

  // Writes to indexes past the key words are dropped
  task automatic test_bad_index();
    write_key(KEY_WORD3_IDX + 8'd1, '1);
    write_key('1, 32'h1234_5678);
    send_block('0, '0);
    send_block('1, '0);
    send_block(32'hDEAD_BEEF, 32'hCAFE_F00D);
    drain_blocks();
  endtask

  // Blocks offered in every cycle, back to back through the pipeline
  task automatic test_back_to_back();
    steady_flow = 1'b1;
    write_all_keys($urandom, $urandom, $urandom, $urandom);
    for (int i = 0; i < 10; i++) send_block($urandom, $urandom);
    drain_blocks();
    steady_flow = 1'b0;
  endtask

  // Random blocks over several key settings, with stretches of full rate in between
  task automatic test_random_blocks();
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p % 4)
        0:       write_all_keys($urandom, $urandom, $urandom, $urandom);
        1:       write_all_keys('1, '0, '1, '0);
        2:       write_all_keys(pick_word(), pick_word(), pick_word(), pick_word());
        default: write_all_keys('0, '1, '0, '1);
      endcase
      if ($urandom_range(0, 2) == 0)
        write_key(cfg_idx_t'($urandom_range(KEY_WORD3_IDX + 1, 255)), $urandom);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 29) == 0) steady_flow = ~steady_flow;
        send_block(pick_word(), pick_word());
      end
      drain_blocks();
      steady_flow = 1'b0;
    end
  endtask

  initial begin
    for (int i = 0; i < 4; i++) key_shadow[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_key();
    test_key_extremes();
    test_bad_index();
    test_back_to_back();
    test_random_blocks();
    repeat (PIPE_DEPTH + 16) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
